// File: design/sdi12ct_pkg.sv
// shared types and constants of the sdi-12 command transmitter
package sdi12ct_pkg;

  // item operation codes (travel in s_tuser)
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  // line phases as reported in the result
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BREAK  = 3'd1,
    PH_MARK   = 3'd2,
    PH_TX     = 3'd3,
    PH_LISTEN = 3'd4
  } phase_e;

  // bit positions inside one ten-bit character frame
  localparam logic [3:0] BitStart  = 4'd0;
  localparam logic [3:0] BitParity = 4'd8;
  localparam logic [3:0] BitStop   = 4'd9;

  // configuration registers
  localparam int unsigned CfgAddrW     = 3;
  localparam logic        RegBreak     = 1'b0;
  localparam logic        RegMark      = 1'b1;
  localparam logic [7:0]  BreakTicksRst = 8'd17;
  localparam logic [7:0]  MarkTicksRst  = 8'd11;

  // width of the reported buffer fill
  localparam int unsigned CountW = 5;

  // one result transaction
  typedef struct packed {
    logic [CountW-1:0] char_count;
    logic              accepted;
    phase_e            phase;
    logic              drive_line;
    logic              line_high;
  } result_t;

endpackage

// File: design/sdi12ct_cmd_buf.sv
// command character buffer with registered read port
module sdi12ct_cmd_buf
  import sdi12ct_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr_i,
  input  logic [6:0]                      wr_data_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr_i,
  output logic [6:0]                      rd_data_o
);

  logic [6:0] mem [BUFFER_DEPTH];

  // write port, loads only happen while idle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data follows the address in the next cycle
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// File: design/sdi12ct_seq.sv
// phase sequencer: break, mark, character framing and buffer fill
module sdi12ct_seq
  import sdi12ct_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            take_i,
  input  op_e                             op_i,
  input  logic [6:0]                      char_i,
  input  logic [7:0]                      break_ticks_i,
  input  logic [7:0]                      mark_ticks_i,
  input  logic [6:0]                      rd_data_i,
  output logic                            wr_en_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr_o,
  output logic [6:0]                      wr_data_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr_o,
  output result_t                         res_o
);

  localparam int unsigned IdxW = $clog2(BUFFER_DEPTH);
  localparam int unsigned LenW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [LenW-1:0] Full = LenW'(BUFFER_DEPTH);

  phase_e          phase_q, phase_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [3:0]      bit_q, bit_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [LenW-1:0] len_q, len_d;
  logic            line_q, line_d;
  logic            acc;
  logic [8:0]      cnt_inc;
  logic [LenW-1:0] idx_next;
  logic [2:0]      data_sel;

  assign cnt_inc  = {1'b0, cnt_q} + 9'd1;
  assign idx_next = LenW'(idx_q) + LenW'(1);
  assign data_sel = bit_q[2:0] - 3'd1;

  // state registers, updated once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      line_q  <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      line_q  <= line_d;
    end
  end

  // next state for the incoming item
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    bit_d     = bit_q;
    idx_d     = idx_q;
    len_d     = len_q;
    line_d    = line_q;
    acc       = 1'b0;
    wr_en_o   = 1'b0;
    case (op_i)
      OP_LOAD: begin
        if (phase_q == PH_IDLE && len_q < Full) begin
          wr_en_o = take_i;
          len_d   = len_q + LenW'(1);
          acc     = 1'b1;
        end
      end
      OP_CLEAR: begin
        phase_d = PH_IDLE;
        cnt_d   = '0;
        bit_d   = '0;
        idx_d   = '0;
        len_d   = '0;
        line_d  = 1'b0;
        acc     = 1'b1;
      end
      OP_START: begin
        if (phase_q == PH_IDLE && len_q != '0) begin
          phase_d = PH_BREAK;
          cnt_d   = '0;
          bit_d   = '0;
          idx_d   = '0;
          line_d  = 1'b1;
          acc     = 1'b1;
        end
      end
      default: begin
        acc = 1'b1;
        case (phase_q)
          // break: line high for break_ticks ticks
          PH_BREAK: begin
            if (cnt_inc >= {1'b0, break_ticks_i}) begin
              phase_d = PH_MARK;
              cnt_d   = '0;
              line_d  = 1'b0;
            end else begin
              cnt_d = cnt_inc[7:0];
            end
          end
          // marking: line low for mark_ticks ticks
          PH_MARK: begin
            if (cnt_inc >= {1'b0, mark_ticks_i}) begin
              phase_d = PH_TX;
              cnt_d   = '0;
              bit_d   = '0;
              idx_d   = '0;
            end else begin
              cnt_d = cnt_inc[7:0];
            end
          end
          // character frames, inverted levels
          PH_TX: begin
            if (bit_q == BitStart) begin
              line_d = 1'b1;
            end else if (bit_q == BitParity) begin
              line_d = ~(^rd_data_i);
            end else if (bit_q == BitStop) begin
              line_d = 1'b0;
            end else begin
              line_d = ~rd_data_i[data_sel];
            end
            if (bit_q == BitStop) begin
              bit_d = '0;
              if (idx_next >= len_q) begin
                phase_d = PH_LISTEN;
                idx_d   = '0;
                line_d  = 1'b0;
              end else begin
                idx_d = idx_next[IdxW-1:0];
              end
            end else begin
              bit_d = bit_q + 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  // buffer access
  assign wr_addr_o = len_q[IdxW-1:0];
  assign wr_data_o = char_i;
  assign rd_addr_o = idx_q;

  // result of this item
  assign res_o.line_high  = line_d;
  assign res_o.drive_line = (phase_d != PH_LISTEN);
  assign res_o.phase      = phase_d;
  assign res_o.accepted   = acc;
  assign res_o.char_count = CountW'(len_d);

endmodule

// File: design/sdi12ct_top_unused_guard.sv
// result register stage between the sequencer and the output stream
module sdi12ct_top_unused_guard
  import sdi12ct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    take_i,
  input  result_t res_i,
  input  logic    m_tready_i,
  output logic    valid_o,
  output logic    ready_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // valid flag of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_i) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      res_q <= res_i;
    end
  end

  // a new item enters when the register is empty or draining
  assign ready_o = !valid_q || m_tready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: design/sdi12_command_transmitter_unit.sv
// top level of the sdi-12 command transmitter
//
// Input stream: s_tuser carries the operation (load, clear, start, tick),
// s_tdata the seven-bit command character used by load. Each accepted
// transaction produces exactly one result transaction on the output stream:
// line level, drive enable, phase, accepted flag and buffer fill.
// Ticks are the bit-period clock of the line; the host sends one per bit.
// The single result register makes a result valid in the cycle after its
// input is accepted; one item is accepted every cycle while results are taken.
// When the receiver stalls, the result register holds its transaction and
// s_tready drops until it is taken; it rises again in the cycle the result
// leaves, so no bubble is added. Reset puts the block in idle with an
// empty buffer, line driven low, break_ticks = 17 and mark_ticks = 11.
// Registers sit on the APB port at 0x0 (break_ticks) and 0x4 (mark_ticks);
// the user must write them only while idle; the block does not enforce it.
// The buffer holds BUFFER_DEPTH characters; start with an empty buffer,
// and load or start outside idle, are reported with accepted = 0.
module sdi12_command_transmitter_unit
  import sdi12ct_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // stream in
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [7:0]          s_tdata_i,   // [6:0] char_value, [7] zero
  input  logic [1:0]          s_tuser_i,   // [1:0] operation
  // stream out
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [15:0]         m_tdata_o,   // [0] line_high, [1] drive_line,
                                           // [4:2] phase, [5] accepted,
                                           // [10:6] char_count, [15:11] zero
  // apb configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IdxW = $clog2(BUFFER_DEPTH);

  logic [7:0]      break_ticks_q;
  logic [7:0]      mark_ticks_q;
  logic            take;
  logic            cfg_wr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [6:0]      wr_data;
  logic [IdxW-1:0] rd_addr;
  logic [6:0]      rd_data;
  result_t         res;
  result_t         res_q;
  op_e             op;

  assign op     = op_e'(s_tuser_i);
  assign take   = s_tvalid_i && s_tready_o;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_ticks_q <= BreakTicksRst;
      mark_ticks_q  <= MarkTicksRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegBreak) begin
        break_ticks_q <= pwdata[7:0];
      end else begin
        mark_ticks_q <= pwdata[7:0];
      end
    end
  end

  // register read back
  assign prdata = (paddr[2] == RegMark) ? {24'd0, mark_ticks_q} : {24'd0, break_ticks_q};

  sdi12ct_cmd_buf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  sdi12ct_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .op_i         (op),
    .char_i       (s_tdata_i[6:0]),
    .break_ticks_i(break_ticks_q),
    .mark_ticks_i (mark_ticks_q),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_addr_o    (rd_addr),
    .res_o        (res)
  );

  sdi12ct_top_unused_guard u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .res_i     (res),
    .m_tready_i(m_tready_i),
    .valid_o   (m_tvalid_o),
    .ready_o   (s_tready_o),
    .res_o     (res_q)
  );

  // pack the result transaction
  assign m_tdata_o = {5'd0, res_q.char_count, res_q.accepted, res_q.phase,
                      res_q.drive_line, res_q.line_high};

`ifndef ASSERT_OFF
  // the line is released exactly in listening
  a_drive_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (res_q.drive_line == (res_q.phase != PH_LISTEN)))
    else $error("drive enable disagrees with phase");

  // idle always drives the line low
  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && res_q.phase == PH_IDLE) |-> !res_q.line_high)
    else $error("line high while idle");

  // a clear empties the buffer and returns to idle
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && op == OP_CLEAR) |=>
      (m_tvalid_o && res_q.phase == PH_IDLE && res_q.char_count == '0
       && res_q.accepted))
    else $error("clear did not return to idle");

  // no item enters while a stalled result is held
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |-> !take)
    else $error("input taken over a stalled result");
`endif

endmodule

// File: sim/sdi12_command_transmitter_unit_tb.sv
// self-checking testbench of the sdi-12 command transmitter unit
module sdi12_command_transmitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdi12ct_pkg::*;

  localparam int ClkPeriod   = 4;
  localparam int BufferDepth = 16;
  localparam int FrameBits   = 10;
  localparam int ItemTarget  = 1500;
  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 8;

  // wait styles of the sender and the receiver
  localparam int WaitNone   = 0;
  localparam int WaitAny    = 1;
  localparam int WaitSparse = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = '0;    // [6:0] char_value, [7] zero
  logic [1:0]  s_tuser_i = '0;    // [1:0] operation
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [15:0] m_tdata_o;         // [0] line_high, [1] drive_line, [4:2] phase,
                                  // [5] accepted, [10:6] char_count
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // line state as the testbench expects it
  phase_e     line_phase;
  int         period_cnt;
  logic [6:0] cmd_chars [BufferDepth];
  int         cmd_len;
  logic       line_lvl;
  logic [7:0] break_len;
  logic [7:0] mark_len;

  result_t expected_line_states[$];

  int tx_mode = WaitNone;
  int rx_mode = WaitNone;
  int rx_pause_cycles = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sequences_run = 0;
  int timings_used = 0;
  int cycle_count = 0;

  sdi12_command_transmitter_unit #(
    .BUFFER_DEPTH(BufferDepth)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // overall timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_wait(int mode);
    case (mode)
      WaitNone: return 0;
      WaitAny:  return $urandom_range(0, 11);
      default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
    endcase
  endfunction

  function automatic logic [6:0] draw_char();
    case ($urandom_range(0, 7))
      0:       return 7'h00;
      1:       return 7'h7f;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic int at_least_one(logic [7:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
    mismatch_count++;
  endtask

  task automatic reset_line_model();
    line_phase = PH_IDLE;
    period_cnt = 0;
    cmd_len    = 0;
    line_lvl   = 1'b0;
    break_len  = BreakTicksRst;
    mark_len   = MarkTicksRst;
    foreach (cmd_chars[i]) cmd_chars[i] = '0;
  endtask

  // one bit period of the line
  task automatic advance_bit_period();
    int         pos;
    int         idx;
    logic [6:0] ch;
    case (line_phase)
      PH_BREAK: begin
        period_cnt++;
        if (period_cnt >= break_len) begin
          line_phase = PH_MARK;
          period_cnt = 0;
          line_lvl   = 1'b0;
        end
      end
      PH_MARK: begin
        period_cnt++;
        if (period_cnt >= mark_len) begin
          line_phase = PH_TX;
          period_cnt = 0;
        end
      end
      PH_TX: begin
        pos = period_cnt % FrameBits;
        idx = period_cnt / FrameBits;
        ch  = (idx < BufferDepth) ? cmd_chars[idx] : 7'h00;
        // inverted levels: a logical one is a low line
        if (pos == BitStart) line_lvl = 1'b1;
        else if (pos == BitParity) line_lvl = ~(^ch);
        else if (pos == BitStop) line_lvl = 1'b0;
        else line_lvl = ~ch[pos-1];
        period_cnt++;
        if (period_cnt / FrameBits >= cmd_len) begin
          line_phase = PH_LISTEN;
          period_cnt = 0;
          line_lvl   = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_line_step(op_e op, logic [6:0] ch, output result_t r);
    logic taken;
    taken = 1'b0;
    case (op)
      OP_LOAD: begin
        if (line_phase == PH_IDLE && cmd_len < BufferDepth) begin
          cmd_chars[cmd_len] = ch;
          cmd_len++;
          taken = 1'b1;
        end
      end
      OP_CLEAR: begin
        line_phase = PH_IDLE;
        cmd_len    = 0;
        period_cnt = 0;
        line_lvl   = 1'b0;
        taken      = 1'b1;
      end
      OP_START: begin
        if (line_phase == PH_IDLE && cmd_len > 0) begin
          line_phase = PH_BREAK;
          period_cnt = 0;
          line_lvl   = 1'b1;
          taken      = 1'b1;
        end
      end
      default: begin
        advance_bit_period();
        taken = 1'b1;
      end
    endcase
    r.line_high  = line_lvl;
    r.drive_line = (line_phase != PH_LISTEN);
    r.phase      = line_phase;
    r.accepted   = taken;
    r.char_count = CountW'(cmd_len);
  endtask

  // offer one transaction and record what it should produce
  task automatic send_item(op_e op, logic [6:0] ch);
    int      gap;
    result_t want;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {1'b0, ch};
    do @(posedge clk_i); while (!s_tready_o);
    predict_line_step(op, ch, want);
    expected_line_states.insert(expected_line_states.size(), want);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(op_e'($urandom_range(0, 3)), draw_char());
  endtask

  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (expected_line_states.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(logic is_write, logic reg_sel, logic [7:0] val,
                            output logic [31:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= CfgAddrW'(4 * int'(reg_sel));
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(logic reg_sel, logic [7:0] want);
    logic [31:0] rd;
    apb_access(1'b0, reg_sel, 8'd0, rd);
    if (rd !== {24'd0, want})
      report_mismatch(reg_sel == RegBreak ? "break_ticks read" : "mark_ticks read",
                      int'(rd), int'(want));
  endtask

  // return to idle, then program both timing registers and read them back
  task automatic set_line_timing(logic [7:0] brk, logic [7:0] mrk);
    logic [31:0] rd;
    send_item(OP_CLEAR, draw_char());
    drain_results();
    apb_access(1'b1, RegBreak, brk, rd);
    break_len = brk;
    apb_access(1'b1, RegMark, mrk, rd);
    mark_len = mrk;
    check_register(RegBreak, brk);
    check_register(RegMark, mrk);
    timings_used++;
  endtask

  // compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (m_tvalid_o && m_tready_i) begin
      got = result_t'(m_tdata_o[10:0]);
      if (m_tdata_o[15:11] !== '0) report_mismatch("padding", int'(m_tdata_o[15:11]), 0);
      if (expected_line_states.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata_o), -1);
      end else begin
        want = expected_line_states.pop_front();
        if (got.line_high !== want.line_high)
          report_mismatch("line_high", int'(got.line_high), int'(want.line_high));
        if (got.drive_line !== want.drive_line)
          report_mismatch("drive_line", int'(got.drive_line), int'(want.drive_line));
        if (got.phase !== want.phase)
          report_mismatch("phase", int'(got.phase), int'(want.phase));
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", int'(got.accepted), int'(want.accepted));
        if (got.char_count !== want.char_count)
          report_mismatch("char_count", int'(got.char_count), int'(want.char_count));
      end
      results_seen++;
    end
  end

  // result receiver: per-transaction stalls plus long holds on request
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid_o && m_tready_i) wait_left = draw_wait(rx_mode);
      if (rx_pause_cycles > 0) begin
        rx_pause_cycles--;
        m_tready_i <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  task automatic test_register_defaults();
    check_register(RegBreak, BreakTicksRst);
    check_register(RegMark, MarkTicksRst);
  endtask

  // every operation, and rejected starts and loads, on a one-character command
  task automatic test_directed_command();
    set_line_timing(8'd1, 8'd1);
    tx_mode = WaitNone;
    rx_mode = WaitNone;
    send_item(OP_TICK, 7'h55);    // tick in idle does nothing
    send_item(OP_START, 7'h2a);   // empty buffer
    send_item(OP_LOAD, 7'h7f);
    send_item(OP_START, 7'h00);
    send_item(OP_START, 7'h00);   // already breaking
    send_item(OP_LOAD, 7'h00);    // not idle
    send_item(OP_TICK, 7'h7f);    // end of break
    send_item(OP_TICK, 7'h00);    // end of mark
    repeat (FrameBits) send_item(OP_TICK, draw_char());
    send_item(OP_TICK, 7'h7f);    // tick while listening
    send_item(OP_LOAD, 7'h01);    // load while listening
    send_item(OP_START, 7'h01);   // start while listening
    send_item(OP_CLEAR, 7'h7f);
    drain_results();
  endtask

  // receiver holds off while loads keep coming, so the input backs up
  task automatic test_output_backpressure();
    tx_mode = WaitNone;
    rx_mode = WaitNone;
    send_item(OP_CLEAR, 7'h00);
    rx_pause_cycles = 200;
    repeat (BufferDepth + 4) send_item(OP_LOAD, draw_char());
    repeat (6) send_noise();
    send_item(OP_CLEAR, 7'h00);
    drain_results();
  endtask

  // optional clear, loads, start and enough ticks to send the whole command
  task automatic run_command_sequence();
    int n;
    int ticks;
    int abort_at;
    tx_mode = $urandom_range(WaitNone, WaitSparse);
    rx_mode = $urandom_range(WaitNone, WaitSparse);
    case ($urandom_range(0, 7))
      0:       n = $urandom_range(BufferDepth, BufferDepth + 3);
      1, 2:    n = $urandom_range(1, BufferDepth);
      default: n = $urandom_range(1, 4);
    endcase
    if ($urandom_range(0, 7) != 0) send_item(OP_CLEAR, draw_char());
    repeat (n) send_item(OP_LOAD, draw_char());
    if ($urandom_range(0, 5) == 0) send_noise();
    send_item(OP_START, draw_char());
    ticks = at_least_one(break_len) + at_least_one(mark_len)
          + FrameBits * ((n < BufferDepth) ? n : BufferDepth) + $urandom_range(0, 3);
    abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ticks - 1) : -1;
    for (int i = 0; i < ticks; i++) begin
      if (i == abort_at) begin
        send_item(OP_CLEAR, draw_char());
        break;
      end
      if ($urandom_range(0, 39) == 0) send_noise();
      send_item(OP_TICK, draw_char());
    end
    sequences_run++;
  endtask

  task automatic test_random_sequences();
    int p;
    int seqs;
    p = 0;
    while (items_sent < ItemTarget) begin
      case (p)
        0:       set_line_timing(8'd255, 8'd255);
        1:       set_line_timing(8'd0, 8'd0);
        2:       set_line_timing(8'd1, 8'd255);
        3:       set_line_timing(8'd255, 8'd1);
        default: begin
          if ($urandom_range(0, 4) == 0)
            set_line_timing(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)));
          else
            set_line_timing(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
        end
      endcase
      seqs = (p < 4) ? 1 : $urandom_range(3, 8);
      repeat (seqs) run_command_sequence();
      p++;
    end
    send_item(OP_CLEAR, draw_char());
    drain_results();
  endtask

  initial begin
    reset_line_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_directed_command();
    test_output_backpressure();
    test_random_sequences();

    $display("sent %0d transactions, checked %0d results over %0d command sequences",
             items_sent, results_seen, sequences_run);
    $display("line timings programmed: %0d, mismatches: %0d", timings_used,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
